@@ rtl/core/sobel_pkg.sv @@
package sobel_pkg;

	// Defaults handed to the top-level parameters.
	localparam int MAX_LINE_WIDTH_DEF = 1024;
	localparam int PIXEL_BITS_DEF     = 8;

	// Configuration register geometry and reset values.
	localparam int CFG_W        = 11;
	localparam int WIDTH_RESET  = 640;
	localparam int HEIGHT_RESET = 480;
	localparam int MIN_DIM      = 3;
	localparam int HEIGHT_LIMIT = 1024;

	// Result fields.
	localparam int MAG_W      = 11;
	localparam int POS_W      = 10;
	localparam int OUT_DATA_W = 32;

	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

endpackage

@@ rtl/core/sobel_edge_magnitude_stream.sv @@
// Pipeline: the pixel that completes a window passes stage 1, stage 2, stage 3, the radicand
// register and the square-root stages before its result enters the output register.
// Throughput: one pixel per cycle, set by the single line-store memory, which is read once and
// written once per pixel; a stalled output holds the whole pipeline.
// Reset: asynchronous, active low; afterwards the line store is cleared entry by entry, during
// which no pixel is taken (configuration writes still are).
module sobel_edge_magnitude_stream
	import sobel_pkg::*;
#(
	parameter int MaxLineWidth = MAX_LINE_WIDTH_DEF,
	parameter int PixelBits    = PIXEL_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration write port.
	input  logic                           cfg_write,
	input  logic [0:0]                     cfg_index,
	input  logic [CFG_W-1:0]               cfg_data,
	// Pixel input. s_tdata: pixel_value, zero padded to whole bytes.
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [((PixelBits+7)/8)*8-1:0] s_tdata,
	// Result output. m_tdata: edge_magnitude [10:0], center_column [20:11],
	// center_row [30:21], one zero bit. m_tlast: frame_last.
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [OUT_DATA_W-1:0]          m_tdata,
	output logic                           m_tlast
);

	// Column counter width, and a width that holds both the register and the line length.
	localparam int ColW  = $clog2(MaxLineWidth);
	localparam int DimW  = ($clog2(MaxLineWidth + 1) > CFG_W) ? $clog2(MaxLineWidth + 1) : CFG_W;
	// Gradient magnitudes reach 4 * (2^PixelBits - 1), so they need PixelBits + 2 bits.
	localparam int AbsW  = PixelBits + 2;
	localparam int GradW = PixelBits + 3;
	localparam int PrW   = 2 * AbsW;
	// The square root has PixelBits + 3 bits; its radicand is taken two bits at a time.
	localparam int RootW = PixelBits + 3;
	localparam int SqW   = 2 * RootW;
	localparam int RemW  = RootW + 3;
	localparam int MagFullW = (RootW > MAG_W) ? RootW : MAG_W;

	// ------------------------------------------------------------------
	// Configuration registers. The user makes writes only while the block is idle; it is not enforced.
	// ------------------------------------------------------------------
	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(WIDTH_RESET);
			height_q <= CFG_W'(HEIGHT_RESET);
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The dimensions in use are saturated: width to 3..MaxLineWidth, height to 3..1024.
	logic [DimW-1:0]  w_eff;
	logic [CFG_W-1:0] h_eff;

	always_comb begin
		if (width_q < CFG_W'(MIN_DIM)) begin
			w_eff = DimW'(MIN_DIM);
		end else if (DimW'(width_q) > DimW'(MaxLineWidth)) begin
			w_eff = DimW'(MaxLineWidth);
		end else begin
			w_eff = DimW'(width_q);
		end
		if (height_q < CFG_W'(MIN_DIM)) begin
			h_eff = CFG_W'(MIN_DIM);
		end else if (height_q > CFG_W'(HEIGHT_LIMIT)) begin
			h_eff = CFG_W'(HEIGHT_LIMIT);
		end else begin
			h_eff = height_q;
		end
	end

	// ------------------------------------------------------------------
	// Pipeline control. The whole pipeline moves together; it holds only
	// while a result sits in the output register and is not taken.
	// ------------------------------------------------------------------
	logic adv;
	logic init_done_q;
	logic in_xfer;

	assign adv      = !(m_tvalid && !m_tready);
	assign s_tready = init_done_q && adv;
	assign in_xfer  = s_tvalid && s_tready;

	// ------------------------------------------------------------------
	// Clearing pass after reset: one line-store entry per cycle.
	// ------------------------------------------------------------------
	logic [ColW-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			init_done_q <= 1'b0;
		end else if (!init_done_q) begin
			if (clr_q == ColW'(MaxLineWidth - 1)) begin
				init_done_q <= 1'b1;
			end else begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Position counters: the column and row of the next pixel.
	// ------------------------------------------------------------------
	logic [ColW-1:0]  col_q;
	logic [POS_W-1:0] row_q;
	logic [DimW-1:0]  col_ext;
	logic [CFG_W-1:0] row_ext;
	logic             emit_c;
	logic             last_c;
	logic             col_end_c;
	logic [DimW-1:0]  ccol_full;

	assign col_ext   = DimW'(col_q);
	assign row_ext   = CFG_W'(row_q);
	assign col_end_c = col_ext >= (w_eff - 1'b1);
	// Only interior windows give a result; a counter left beyond a shrunken frame gives none.
	assign emit_c    = (row_ext >= CFG_W'(2)) && (col_ext >= DimW'(2)) &&
		(row_ext < h_eff) && (col_ext < w_eff);
	assign last_c    = (row_ext == h_eff - 1'b1) && (col_ext == w_eff - 1'b1);
	assign ccol_full = col_ext - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_xfer) begin
			if (col_end_c) begin
				col_q <= '0;
				// The row wraps to zero after the last line of the frame.
				if (row_ext >= h_eff - 1'b1) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + 1'b1;
				end
			end else begin
				col_q <= ColW'(col_ext + 1'b1);
			end
		end
	end

	// ------------------------------------------------------------------
	// Line store: one memory whose entry holds the upper line's pixel in the
	// low half and the middle line's pixel in the high half of each column.
	// It is read when a pixel is transferred and written back as that pixel
	// leaves the first stage. Consecutive pixels never share a column, so a
	// read never meets the write-back of the same entry in one cycle.
	// ------------------------------------------------------------------
	logic [2*PixelBits-1:0] lb_mem [MaxLineWidth];
	logic [2*PixelBits-1:0] rd_q;
	logic                   mem_we;
	logic [ColW-1:0]        mem_waddr;
	logic [2*PixelBits-1:0] mem_wdata;

	// Stage 1: the transferred pixel and its position flags.
	logic                   v_s1;
	logic                   rv_s1;
	logic                   last_s1;
	logic [ColW-1:0]        addr_s1;
	logic [POS_W-1:0]       ccol_s1;
	logic [POS_W-1:0]       crow_s1;
	logic [PixelBits-1:0]   bot_s1;

	logic [PixelBits-1:0]   top_c;
	logic [PixelBits-1:0]   mid_c;

	assign top_c = rd_q[PixelBits-1:0];
	assign mid_c = rd_q[2*PixelBits-1:PixelBits];

	always_comb begin
		if (!init_done_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = v_s1 && adv;
			mem_waddr = addr_s1;
			mem_wdata = {bot_s1, mid_c};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			lb_mem[mem_waddr] <= mem_wdata;
		end
		if (in_xfer) begin
			rd_q <= lb_mem[col_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			rv_s1 <= 1'b0;
		end else if (adv) begin
			v_s1  <= in_xfer;
			rv_s1 <= in_xfer && emit_c;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			last_s1 <= last_c;
			addr_s1 <= col_q;
			ccol_s1 <= ccol_full[POS_W-1:0];
			crow_s1 <= row_q - 1'b1;
			bot_s1  <= s_tdata[PixelBits-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Window: the two previous columns of the 3x3 neighbourhood. Entries
	// 0..2 are the older column (upper, middle, lower), 3..5 the newer one.
	// ------------------------------------------------------------------
	logic [PixelBits-1:0] win_q [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (v_s1 && adv) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top_c;
			win_q[4] <= mid_c;
			win_q[5] <= bot_s1;
		end
	end

	// Sobel gradients with weights 1, 2, 1; the newest column comes from the memory and bot_s1.
	logic [AbsW-1:0]         gx_pos;
	logic [AbsW-1:0]         gx_neg;
	logic [AbsW-1:0]         gy_pos;
	logic [AbsW-1:0]         gy_neg;
	logic signed [GradW-1:0] gx_c;
	logic signed [GradW-1:0] gy_c;
	logic signed [GradW-1:0] gx_abs;
	logic signed [GradW-1:0] gy_abs;

	always_comb begin
		gx_pos = AbsW'(top_c) + (AbsW'(mid_c) << 1) + AbsW'(bot_s1);
		gx_neg = AbsW'(win_q[0]) + (AbsW'(win_q[1]) << 1) + AbsW'(win_q[2]);
		gy_pos = AbsW'(win_q[2]) + (AbsW'(win_q[5]) << 1) + AbsW'(bot_s1);
		gy_neg = AbsW'(win_q[0]) + (AbsW'(win_q[3]) << 1) + AbsW'(top_c);
		gx_c   = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
		gy_c   = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
		gx_abs = gx_c[GradW-1] ? -gx_c : gx_c;
		gy_abs = gy_c[GradW-1] ? -gy_c : gy_c;
	end

	// Stage 2: absolute gradients.
	logic              rv_s2;
	logic              last_s2;
	logic [POS_W-1:0]  ccol_s2;
	logic [POS_W-1:0]  crow_s2;
	logic [AbsW-1:0]   gxa_s2;
	logic [AbsW-1:0]   gya_s2;

	// Stage 3: squared gradients.
	logic              rv_s3;
	logic              last_s3;
	logic [POS_W-1:0]  ccol_s3;
	logic [POS_W-1:0]  crow_s3;
	logic [PrW-1:0]    sqx_s3;
	logic [PrW-1:0]    sqy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s2 <= 1'b0;
			rv_s3 <= 1'b0;
		end else if (adv) begin
			rv_s2 <= rv_s1;
			rv_s3 <= rv_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s2 <= last_s1;
			ccol_s2 <= ccol_s1;
			crow_s2 <= crow_s1;
			gxa_s2  <= gx_abs[AbsW-1:0];
			gya_s2  <= gy_abs[AbsW-1:0];
			last_s3 <= last_s2;
			ccol_s3 <= ccol_s2;
			crow_s3 <= crow_s2;
			sqx_s3  <= gxa_s2 * gxa_s2;
			sqy_s3  <= gya_s2 * gya_s2;
		end
	end

	// ------------------------------------------------------------------
	// Square root: one result bit per stage, restoring digit recurrence.
	// Entry 0 holds the radicand; entry RootW holds the finished root.
	// ------------------------------------------------------------------
	logic              sq_rv_s   [RootW+1];
	logic              sq_last_s [RootW+1];
	logic [POS_W-1:0]  sq_ccol_s [RootW+1];
	logic [POS_W-1:0]  sq_crow_s [RootW+1];
	logic [SqW-1:0]    sq_val_s  [RootW+1];
	logic [RemW-1:0]   sq_rem_s  [RootW+1];
	logic [RootW-1:0]  sq_root_s [RootW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_rv_s[0] <= 1'b0;
		end else if (adv) begin
			sq_rv_s[0] <= rv_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_last_s[0] <= last_s3;
			sq_ccol_s[0] <= ccol_s3;
			sq_crow_s[0] <= crow_s3;
			sq_val_s[0]  <= SqW'(sqx_s3) + SqW'(sqy_s3);
			sq_rem_s[0]  <= '0;
			sq_root_s[0] <= '0;
		end
	end

	for (genvar k = 0; k < RootW; k++) begin : g_sqrt
		logic [RemW-1:0] pre;
		logic [RemW-1:0] trial;
		logic            fits;

		always_comb begin
			pre   = {sq_rem_s[k][RemW-3:0], sq_val_s[k][SqW-1 -: 2]};
			trial = RemW'({sq_root_s[k], 2'b01});
			fits  = pre >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_rv_s[k+1] <= 1'b0;
			end else if (adv) begin
				sq_rv_s[k+1] <= sq_rv_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_last_s[k+1] <= sq_last_s[k];
				sq_ccol_s[k+1] <= sq_ccol_s[k];
				sq_crow_s[k+1] <= sq_crow_s[k];
				sq_val_s[k+1]  <= sq_val_s[k] << 2;
				sq_rem_s[k+1]  <= fits ? (pre - trial) : pre;
				sq_root_s[k+1] <= {sq_root_s[k][RootW-2:0], fits};
			end
		end
	end

	// ------------------------------------------------------------------
	// Output register.
	// ------------------------------------------------------------------
	logic                 out_valid_q;
	logic [MAG_W-1:0]     out_mag_q;
	logic [POS_W-1:0]     out_ccol_q;
	logic [POS_W-1:0]     out_crow_q;
	logic                 out_last_q;
	logic [MagFullW-1:0]  mag_ext;

	// The magnitude is not clamped: bits above the field are dropped.
	assign mag_ext = MagFullW'(sq_root_s[RootW]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= sq_rv_s[RootW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_mag_q  <= mag_ext[MAG_W-1:0];
			out_ccol_q <= sq_ccol_s[RootW];
			out_crow_q <= sq_crow_s[RootW];
			out_last_q <= sq_last_s[RootW];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DATA_W'({out_crow_q, out_ccol_q, out_mag_q});
	assign m_tlast  = out_last_q;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	// No pixel is taken before the line store has been cleared.
	a_no_xfer_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> init_done_q)
		else $error("pixel transfer during the clearing pass");

	// A read of the line store never coincides with the write-back of the same column.
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && mem_we |-> mem_waddr != col_q)
		else $error("line store read and write hit the same entry");

	// A stalled first stage keeps its pixel and its memory data until it moves on.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv |=> v_s1 && $stable(addr_s1) && $stable(rd_q) && $stable(bot_s1))
		else $error("first stage lost its pixel during a stall");

	// The write-back only happens for a pixel that is present in the first stage.
	a_wb_has_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		init_done_q && mem_we |-> v_s1 && adv)
		else $error("line store written without a pixel");

endmodule

@@ dv/sobel_edge_magnitude_stream_tb.sv @@
`timescale 1ns / 1ps

module sobel_edge_magnitude_stream_tb;
	import sobel_pkg::*;

	// One result transfer, split into its fields.
	typedef struct {
		logic [MAG_W-1:0] magnitude;
		logic [POS_W-1:0] column;
		logic [POS_W-1:0] row;
		logic             last;
	} edge_result_t;

	// Picture content used for a run of pixels.
	typedef enum int unsigned {
		TEX_NOISE,
		TEX_BINARY,
		TEX_RAMP,
		TEX_FLAT
	} texture_t;

	localparam int unsigned SETTLE_CYCLES    = 40;   // comfortably past the pipeline latency
	localparam int unsigned DRAIN_LIMIT      = 5000;
	localparam int unsigned LONG_HOLD_CYCLES = 400;
	localparam int unsigned RANDOM_PIXELS    = 400;

	// Tracks the line stores, the 3x3 window and the raster position exactly as the block
	// should, and keeps the magnitudes that are owed by the block in arrival order.
	class window_tracker;
		logic [CFG_W-1:0] width_reg;
		logic [CFG_W-1:0] height_reg;
		logic [7:0]       upper_line[MAX_LINE_WIDTH_DEF];
		logic [7:0]       middle_line[MAX_LINE_WIDTH_DEF];
		logic [7:0]       window[6];
		int unsigned      next_column;
		int unsigned      next_row;
		edge_result_t     results_due[$];
		int unsigned      mismatches;

		function new();
			width_reg  = CFG_W'(WIDTH_RESET);
			height_reg = CFG_W'(HEIGHT_RESET);
			foreach (upper_line[i]) begin
				upper_line[i]  = '0;
				middle_line[i] = '0;
			end
			foreach (window[i]) window[i] = '0;
			next_column = 0;
			next_row    = 0;
			mismatches  = 0;
		endfunction

		// A dimension register outside 3..hi is used as the nearest limit.
		static function int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned hi);
			if (v < MIN_DIM) return MIN_DIM;
			if (v > hi) return hi;
			return v;
		endfunction

		static function int unsigned floor_sqrt(int unsigned v);
			int unsigned root;
			int unsigned trial;
			root = 0;
			for (int b = 11; b >= 0; b--) begin
				trial = root | (32'd1 << b);
				if (trial * trial <= v) root = trial;
			end
			return root;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] v);
			case (idx)
				REG_IMAGE_WIDTH:  width_reg  = v;
				REG_IMAGE_HEIGHT: height_reg = v;
				default: ;
			endcase
		endfunction

		function void take_pixel(logic [7:0] px);
			int unsigned  w, h, c, r;
			int           a0, a1, a2, b0, b2, c0, c1, c2, gx, gy;
			logic [7:0]   top, mid;
			edge_result_t res;
			w   = clamp_dim(width_reg, MAX_LINE_WIDTH_DEF);
			h   = clamp_dim(height_reg, HEIGHT_LIMIT);
			c   = next_column;
			r   = next_row;
			top = upper_line[c];
			mid = middle_line[c];
			if (r >= 2 && c >= 2 && r < h && c < w) begin
				// Rows a (top) to c (bottom), columns 0 (oldest) to 2 (incoming).
				a0 = window[0];
				b0 = window[1];
				c0 = window[2];
				a1 = window[3];
				c1 = window[5];
				a2 = top;
				b2 = mid;
				c2 = px;
				gx = (a2 + 2 * b2 + c2) - (a0 + 2 * b0 + c0);
				gy = (c0 + 2 * c1 + c2) - (a0 + 2 * a1 + a2);
				if (gx < 0) gx = -gx;
				if (gy < 0) gy = -gy;
				res.magnitude = MAG_W'(floor_sqrt(gx * gx + gy * gy));
				res.column    = POS_W'(c - 1);
				res.row       = POS_W'(r - 1);
				res.last      = (r == h - 1) && (c == w - 1);
				results_due.push_back(res);
			end
			window[0] = window[3];
			window[1] = window[4];
			window[2] = window[5];
			window[3] = top;
			window[4] = mid;
			window[5] = px;
			upper_line[c]  = mid;
			middle_line[c] = px;
			if (c >= w - 1) begin
				next_column = 0;
				next_row    = (r >= h - 1) ? 0 : r + 1;
			end else begin
				next_column = c + 1;
			end
		endfunction

		function void report_mismatch(string text);
			mismatches++;
			if (mismatches <= 10) $display("MISMATCH %0t: %s", $realtime, text);
		endfunction

		function void check_result(logic [OUT_DATA_W-1:0] data, logic last_flag);
			edge_result_t want;
			logic [MAG_W-1:0] got_mag;
			logic [POS_W-1:0] got_col;
			logic [POS_W-1:0] got_row;
			got_mag = data[MAG_W-1:0];
			got_col = data[MAG_W+POS_W-1:MAG_W];
			got_row = data[MAG_W+2*POS_W-1:MAG_W+POS_W];
			if (results_due.size() == 0) begin
				report_mismatch($sformatf("result with none owed: mag %0d col %0d row %0d last %b",
					got_mag, got_col, got_row, last_flag));
				return;
			end
			want = results_due.pop_front();
			if (got_mag !== want.magnitude || got_col !== want.column || got_row !== want.row
					|| last_flag !== want.last || data[OUT_DATA_W-1] !== 1'b0) begin
				report_mismatch($sformatf(
					"expected mag %0d col %0d row %0d last %b, got mag %0d col %0d row %0d last %b pad %b",
					want.magnitude, want.column, want.row, want.last,
					got_mag, got_col, got_row, last_flag, data[OUT_DATA_W-1]));
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write;
	logic [0:0]            cfg_index;
	logic [CFG_W-1:0]      cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [7:0]            s_tdata;   // pixel_value
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;   // edge_magnitude, center_column, center_row, zero pad
	logic                  m_tlast;   // frame_last

	window_tracker tracker;

	// Per-phase switches for the random gaps on either side, and a one-shot request that
	// makes the receiver refuse transfers for a long stretch.
	bit src_idle_on;
	bit snk_idle_on;
	bit long_hold_req;

	sobel_edge_magnitude_stream uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// A run that has not finished by this limit is reported as NOT OK.
	initial begin
		#400_000;
		$display("sobel_edge_magnitude_stream_tb NOT OK");
		$finish;
	end

	// Both dimension registers are written back to back, so the write enable simply stays
	// high across both writes. The model is updated at the edge that performs each write.
	task automatic write_dims(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
		cfg_write <= 1'b1;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		tracker.write_reg(REG_IMAGE_WIDTH, w);
		@(negedge clk);
		cfg_index <= REG_IMAGE_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		tracker.write_reg(REG_IMAGE_HEIGHT, h);
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// Offers one pixel and returns on the falling edge after its transfer. The valid is
	// only lowered when a gap is actually taken, so back-to-back pixels keep it high.
	task automatic send_pixel(input logic [7:0] px);
		int unsigned gap;
		gap = src_idle_on ? $urandom_range(0, 8) : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= px;
		do @(posedge clk); while (!s_tready);
		tracker.take_pixel(px);
		@(negedge clk);
	endtask

	function automatic logic [7:0] pick_pixel(texture_t tex, int unsigned n);
		case (tex)
			TEX_NOISE:  return 8'($urandom_range(0, 255));
			TEX_BINARY: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			TEX_RAMP:   return 8'(n * 7);
			default:    return 8'($urandom_range(120, 136));
		endcase
	endfunction

	task automatic send_run(input int unsigned count, input texture_t tex);
		for (int unsigned i = 0; i < count; i++) send_pixel(pick_pixel(tex, i));
	endtask

	// Stops offering pixels and waits for every owed result. A pixel that causes no result
	// may still be inside the pipeline at that point, hence the settling cycles after it,
	// which also make the block safe to reconfigure.
	task automatic wait_idle();
		int unsigned spent;
		s_tvalid <= 1'b0;
		spent = 0;
		while (tracker.results_due.size() != 0 && spent < DRAIN_LIMIT) begin
			@(negedge clk);
			spent++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [CFG_W-1:0] pick_dim();
		// Mostly small frames so that many frame ends are seen; sometimes a value below the
		// legal range, which the block must treat as three.
		if ($urandom_range(0, 9) == 0) return CFG_W'($urandom_range(0, 2));
		return CFG_W'($urandom_range(3, 16));
	endfunction

	// Result side: draws a stall before every transfer while sink gaps are on, and checks each
	// result at the edge that completes its transfer.
	initial begin
		int unsigned hold;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			hold = snk_idle_on ? $urandom_range(0, 8) : 0;
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold += LONG_HOLD_CYCLES;
			end
			if (hold != 0) begin
				m_tready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			tracker.check_result(m_tdata, m_tlast);
			@(negedge clk);
		end
	end

	initial begin
		static logic [7:0] corner_frames[27] = '{
			// A vertical and a diagonal edge, then a flat frame, then edges of the
			// opposite sign so that both gradients come out negative before the absolute value.
			8'd0,   8'd0,   8'd255,  8'd0,   8'd128, 8'd255,  8'd0,   8'd255, 8'd255,
			8'd255, 8'd255, 8'd255,  8'd255, 8'd255, 8'd255,  8'd255, 8'd255, 8'd255,
			8'd255, 8'd255, 8'd0,    8'd255, 8'd0,   8'd0,    8'd0,   8'd0,   8'd0
		};
		int unsigned random_sent;
		int unsigned frame_w;
		int unsigned frame_h;
		int unsigned count;
		logic [CFG_W-1:0] dim_w;
		logic [CFG_W-1:0] dim_h;

		tracker       = new();
		arst_n        = 1'b0;
		cfg_write     = 1'b0;
		cfg_index     = REG_IMAGE_WIDTH;
		cfg_data      = '0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		src_idle_on   = 1'b0;
		snk_idle_on   = 1'b0;
		long_hold_req = 1'b0;
		random_sent   = 0;

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// Three smallest frames back to back. The first transfer only happens once the block
		// has finished clearing its line store after reset, which send_pixel waits out.
		write_dims(11'd3, 11'd3);
		foreach (corner_frames[i]) send_pixel(corner_frames[i]);
		wait_idle();

		// Stop part-way through the sixth line of a 12x8 frame, then shrink the frame below
		// the current position: the next pixel must give no result and wrap both counters.
		src_idle_on = 1'b1;
		snk_idle_on = 1'b1;
		write_dims(11'd12, 11'd8);
		send_run(5 * 12 + 9, TEX_NOISE);
		wait_idle();
		write_dims(11'd4, 11'd2);
		send_run(1 + 2 * 4 * 3, TEX_BINARY);
		wait_idle();

		// A height under the minimum, which must be used as three. Pixels stream without
		// gaps while the receiver stops for a long stretch after the first result, so the
		// pipeline fills and back-pressures its input.
		src_idle_on   = 1'b0;
		snk_idle_on   = 1'b0;
		long_hold_req = 1'b1;
		write_dims(11'd24, 11'd0);
		send_run(3 * 24, TEX_NOISE);
		wait_idle();

		// Tallest frame on the narrowest line, with gaps on both sides; it is left part-way
		// so that the following phase reconfigures inside it.
		src_idle_on = 1'b1;
		snk_idle_on = 1'b1;
		write_dims(11'd1, CFG_W'(HEIGHT_LIMIT));
		send_run(60, TEX_RAMP);
		wait_idle();

		// Random frame shapes. Most phases send whole frames; one in three may stop mid-frame so
		// that the following phase reconfigures with the counters somewhere inside it.
		while (random_sent < RANDOM_PIXELS) begin
			dim_w = pick_dim();
			dim_h = pick_dim();
			if ($urandom_range(0, 15) == 0) dim_h = 11'd1025;
			write_dims(dim_w, dim_h);
			frame_w = window_tracker::clamp_dim(dim_w, MAX_LINE_WIDTH_DEF);
			frame_h = window_tracker::clamp_dim(dim_h, HEIGHT_LIMIT);
			// A saturated height would make the frame far too long; such phases stay short.
			if (frame_h > 16) frame_h = 4;
			src_idle_on = $urandom_range(0, 3) != 0;
			snk_idle_on = $urandom_range(0, 3) != 0;
			if ($urandom_range(0, 2) == 0)
				count = $urandom_range(1, frame_w * frame_h);
			else
				count = frame_w * frame_h * $urandom_range(1, 2);
			if (count > RANDOM_PIXELS - random_sent) count = RANDOM_PIXELS - random_sent;
			send_run(count, texture_t'($urandom_range(0, 3)));
			random_sent += count;
			wait_idle();
		end

		if (tracker.results_due.size() != 0)
			$display("%0d owed results never arrived", tracker.results_due.size());
		if (tracker.mismatches == 0 && tracker.results_due.size() == 0) begin
			$display("sobel_edge_magnitude_stream_tb OK");
		end else begin
			$display("sobel_edge_magnitude_stream_tb NOT OK");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/sobel_pkg.sv
rtl/core/sobel_edge_magnitude_stream.sv
dv/sobel_edge_magnitude_stream_tb.sv
